@@ rtl/y2prgb_pkg.sv @@
// Shared types, constants and helpers for the YUVA to premultiplied RGBA converter.
package y2prgb_pkg;

  localparam int PIX_W       = 8;
  localparam int COEF_W      = 16;
  localparam int COEFS_W     = 3 * COEF_W;
  localparam int OFFSET_W    = 16;
  localparam int OFFSET_FRAC = 6;
  localparam int CFG_DATA_W  = COEFS_W;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = COEF_W + PIX_W + 1;
  localparam int PREMUL_W    = 2 * PIX_W;

  typedef logic [PIX_W-1:0]           pix_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [COEFS_W-1:0]         coefs_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  localparam pix_t PIX_MAX      = 8'hFF;
  localparam pix_t PIX_ZERO     = 8'h00;
  localparam pix_t OPAQUE_ALPHA = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_COEFS   = 3'd0,
    REG_GREEN_COEFS = 3'd1,
    REG_BLUE_COEFS  = 3'd2,
    REG_RED_OFFSET  = 3'd3,
    REG_GREEN_OFFSET = 3'd4,
    REG_BLUE_OFFSET = 3'd5
  } cfg_reg_e;

  // Width of the signed channel sum: three products, the aligned offset and
  // the rounding half, with headroom for the carries.
  function automatic int sum_width(int frac);
    return (((frac + 10) > 25) ? (frac + 10) : 25) + 3;
  endfunction

endpackage

@@ rtl/yuva_to_premul_rgba_top.sv @@
// Top level of the YUVA to premultiplied RGBA pixel converter.
//
//  channel   ports                                           direction
//  --------  ----------------------------------------------  ---------
//  pixel in  start, luma, chroma_blue, chroma_red, alpha_in  in
//            and busy, which is out
//  pixel out done, red_out, green_out, blue_out, alpha_out    out
//  config    cfg_write, cfg_index, cfg_data                   in
//
// An item is taken on every clock where start is high; busy stays low, so a
// new pixel may enter every cycle. Each item comes out on a one-cycle done
// strobe after passing two stages for the matrix multiply-add, one for the
// clamp and alpha multiply, one for the divide-by-255 fold. rst clears the
// valid pipeline and the matrix registers; items in flight are dropped. The
// receiver cannot stall, so the pipeline never holds.
module yuva_to_premul_rgba_top #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  y2prgb_pkg::pix_t            luma,
  input  y2prgb_pkg::pix_t            chroma_blue,
  input  y2prgb_pkg::pix_t            chroma_red,
  input  y2prgb_pkg::pix_t            alpha_in,
  output logic                        done,
  output y2prgb_pkg::pix_t            red_out,
  output y2prgb_pkg::pix_t            green_out,
  output y2prgb_pkg::pix_t            blue_out,
  output y2prgb_pkg::pix_t            alpha_out,
  input  logic                        cfg_write,
  input  logic [y2prgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  y2prgb_pkg::cfg_data_t       cfg_data
);
  import y2prgb_pkg::*;

  localparam int SUM_W  = sum_width(COEF_FRAC_BITS);
  localparam int DEPTH  = 4;
  localparam int PREMUL_STAGE = 2;

  // Matrix registers.
  coefs_t  red_coefs;
  coefs_t  green_coefs;
  coefs_t  blue_coefs;
  offset_t red_offset;
  offset_t green_offset;
  offset_t blue_offset;

  logic [DEPTH-1:0] vld;
  pix_t             alpha_pipe [DEPTH];

  logic signed [SUM_W-1:0] red_sum;
  logic signed [SUM_W-1:0] green_sum;
  logic signed [SUM_W-1:0] blue_sum;

  logic accept;

  // The datapath is fully pipelined and never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_coefs    <= '0;
      green_coefs  <= '0;
      blue_coefs   <= '0;
      red_offset   <= '0;
      green_offset <= '0;
      blue_offset  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_RED_COEFS:    red_coefs    <= cfg_data;
        REG_GREEN_COEFS:  green_coefs  <= cfg_data;
        REG_BLUE_COEFS:   blue_coefs   <= cfg_data;
        REG_RED_OFFSET:   red_offset   <= cfg_data[OFFSET_W-1:0];
        REG_GREEN_OFFSET: green_offset <= cfg_data[OFFSET_W-1:0];
        REG_BLUE_OFFSET:  blue_offset  <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits advance one stage a cycle alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  // Alpha rides along: tapped for the premultiply and delivered at the end.
  always_ff @(posedge clk) begin
    alpha_pipe[0] <= alpha_in;
    for (int i = 1; i < DEPTH; i++) begin
      alpha_pipe[i] <= alpha_pipe[i-1];
    end
  end

  y2prgb_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .SUM_W(SUM_W)) u_red_row (
    .clk(clk), .luma(luma), .chroma_blue(chroma_blue), .chroma_red(chroma_red),
    .coefs(red_coefs), .offset(red_offset), .sum(red_sum)
  );

  y2prgb_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .SUM_W(SUM_W)) u_green_row (
    .clk(clk), .luma(luma), .chroma_blue(chroma_blue), .chroma_red(chroma_red),
    .coefs(green_coefs), .offset(green_offset), .sum(green_sum)
  );

  y2prgb_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .SUM_W(SUM_W)) u_blue_row (
    .clk(clk), .luma(luma), .chroma_blue(chroma_blue), .chroma_red(chroma_red),
    .coefs(blue_coefs), .offset(blue_offset), .sum(blue_sum)
  );

  y2prgb_premul #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .SUM_W(SUM_W)) u_red_pm (
    .clk(clk), .sum(red_sum), .alpha(alpha_pipe[PREMUL_STAGE-1]), .color(red_out)
  );

  y2prgb_premul #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .SUM_W(SUM_W)) u_green_pm (
    .clk(clk), .sum(green_sum), .alpha(alpha_pipe[PREMUL_STAGE-1]), .color(green_out)
  );

  y2prgb_premul #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .SUM_W(SUM_W)) u_blue_pm (
    .clk(clk), .sum(blue_sum), .alpha(alpha_pipe[PREMUL_STAGE-1]), .color(blue_out)
  );

  assign done      = vld[DEPTH-1];
  assign alpha_out = alpha_pipe[DEPTH-1];

  // Every strobe traces back to an item accepted through the full depth of the valid pipeline.
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, DEPTH))
    else $error("done without a matching accepted item");

  // Alpha leaves aligned with the colors of its own pixel.
  a_alpha_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (alpha_out == $past(alpha_in, DEPTH)))
    else $error("alpha_out misaligned with its item");

  // Fully transparent pixels premultiply to black.
  a_transparent_black: assert property (@(posedge clk) disable iff (rst)
    (done && (alpha_out == PIX_ZERO)) |->
      ((red_out == PIX_ZERO) && (green_out == PIX_ZERO) && (blue_out == PIX_ZERO)))
    else $error("transparent pixel has nonzero color");

endmodule

@@ rtl/y2prgb_matrix.sv @@
// One row of the color matrix: three products, then offset, rounding and sum.
module y2prgb_matrix #(
  parameter int COEF_FRAC_BITS = 12,
  parameter int SUM_W          = 28
) (
  input  logic                     clk,
  input  y2prgb_pkg::pix_t         luma,
  input  y2prgb_pkg::pix_t         chroma_blue,
  input  y2prgb_pkg::pix_t         chroma_red,
  input  y2prgb_pkg::coefs_t       coefs,
  input  y2prgb_pkg::offset_t      offset,
  output logic signed [SUM_W-1:0]  sum
);
  import y2prgb_pkg::*;

  localparam int OFF_SHIFT = COEF_FRAC_BITS - OFFSET_FRAC;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

  coef_t coef_y;
  coef_t coef_u;
  coef_t coef_v;

  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_u;
  logic signed [PROD_W-1:0] prod_v;
  logic signed [SUM_W-1:0]  bias;

  assign coef_y = coefs[COEF_W-1:0];
  assign coef_u = coefs[2*COEF_W-1:COEF_W];
  assign coef_v = coefs[3*COEF_W-1:2*COEF_W];

  // Stage one: products and the aligned bias with the rounding half folded in.
  always_ff @(posedge clk) begin
    prod_y <= coef_y * $signed({1'b0, luma});
    prod_u <= coef_u * $signed({1'b0, chroma_blue});
    prod_v <= coef_v * $signed({1'b0, chroma_red});
    bias   <= (SUM_W'(offset) <<< OFF_SHIFT) + ROUND_HALF;
  end

  // Stage two: sum.
  always_ff @(posedge clk) begin
    sum <= SUM_W'(prod_y) + SUM_W'(prod_u) + SUM_W'(prod_v) + bias;
  end

endmodule

@@ rtl/y2prgb_premul.sv @@
// Clamp one channel sum to 0..255 and premultiply it by alpha.
module y2prgb_premul #(
  parameter int COEF_FRAC_BITS = 12,
  parameter int SUM_W          = 28
) (
  input  logic                     clk,
  input  logic signed [SUM_W-1:0]  sum,
  input  y2prgb_pkg::pix_t         alpha,
  output y2prgb_pkg::pix_t         color
);
  import y2prgb_pkg::*;

  pix_t                clamped;
  pix_t                color_hold;
  logic                opaque;
  logic [PREMUL_W-1:0] prod;
  logic [PREMUL_W-1:0] folded;

  always_comb begin
    priority if (sum[SUM_W-1]) begin
      clamped = PIX_ZERO;
    end else if (|sum[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
      clamped = PIX_MAX;
    end else begin
      clamped = sum[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    end
  end

  // Stage three: clamp and c*a + 128; keep the clamped value for opaque alpha.
  always_ff @(posedge clk) begin
    prod       <= ({8'b0, clamped} * {8'b0, alpha}) + PREMUL_W'(128);
    color_hold <= clamped;
    opaque     <= (alpha == OPAQUE_ALPHA);
  end

  assign folded = prod + {8'b0, prod[PREMUL_W-1:PIX_W]};

  // Stage four: divide by 255 with rounding, or pass through when opaque.
  always_ff @(posedge clk) begin
    color <= opaque ? color_hold : folded[PREMUL_W-1:PIX_W];
  end

endmodule
